// ----- design/cpu_usage_decaying_average_assert.svh -----
// Assertion macros shared by the decaying CPU-usage average design.
// Depends on nothing; included inside the module that checks itself.
`ifndef CPU_USAGE_DECAYING_AVERAGE_ASSERT_SVH
`define CPU_USAGE_DECAYING_AVERAGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CUDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CUDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cpuavg_pkg.sv -----
// Package for the decaying CPU-usage average: widths, codes, shared types
// and the decay coefficient tables. Used by every module of the design.
package cpuavg_pkg;

    localparam int unsigned WORD_W            = 32;
    localparam int unsigned FRACTION_BITS_DEF = 11;
    localparam int unsigned TABLE_Q           = 16;
    localparam int unsigned RATE_W            = 14;
    localparam int unsigned CMD_W             = 2;
    localparam int unsigned CUR_W             = 21;
    localparam int unsigned EST_W             = 21;
    localparam int unsigned S_TDATA_W         = 32;
    localparam int unsigned M_TDATA_W         = 80;
    localparam int unsigned M_PAD_W           = M_TDATA_W - WORD_W - CUR_W - EST_W;
    localparam int unsigned PADDR_W           = 3;

    localparam logic [RATE_W-1:0] RATE_RESET  = 14'd60;
    localparam logic [WORD_W-1:0] DECAY_LIMIT = 32'd152;
    localparam logic [WORD_W-1:0] LOW_LIMIT   = 32'd7;
    localparam logic [WORD_W-1:0] PERCENT     = 32'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic              start;
        alu_op_t           op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_M_DIV,
        ST_M_MUL1,
        ST_M_MUL2,
        ST_MERGED,
        ST_SECS_DIV,
        ST_BASE_MUL,
        ST_HIGH_MUL,
        ST_LOW_MUL,
        ST_FINISH,
        ST_EST_MUL,
        ST_OUTPUT
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_REST,
        PH_FINAL
    } phase_t;

    // Decay by e^(-(idx+1)/20) in Q16, scaled down to the fraction width.
    function automatic logic [WORD_W-1:0] low_coef(input logic [2:0] idx,
                                                   input int unsigned shift);
        logic [15:0] q;
        case (idx)
            3'd0:    q = 16'd62339;
            3'd1:    q = 16'd59299;
            3'd2:    q = 16'd56407;
            3'd3:    q = 16'd53656;
            3'd4:    q = 16'd51039;
            3'd5:    q = 16'd48550;
            3'd6:    q = 16'd46182;
            default: q = 16'd0;
        endcase
        return WORD_W'(q) >> shift;
    endfunction

    // Decay by e^(-8(idx+1)/20) in Q16, scaled down to the fraction width.
    function automatic logic [WORD_W-1:0] high_coef(input logic [4:0] idx,
                                                    input int unsigned shift);
        logic [15:0] q;
        case (idx)
            5'd0:    q = 16'd43930;
            5'd1:    q = 16'd29447;
            5'd2:    q = 16'd19739;
            5'd3:    q = 16'd13231;
            5'd4:    q = 16'd8869;
            5'd5:    q = 16'd5945;
            5'd6:    q = 16'd3985;
            5'd7:    q = 16'd2671;
            5'd8:    q = 16'd1790;
            5'd9:    q = 16'd1200;
            5'd10:   q = 16'd804;
            5'd11:   q = 16'd539;
            5'd12:   q = 16'd361;
            5'd13:   q = 16'd242;
            5'd14:   q = 16'd162;
            5'd15:   q = 16'd108;
            5'd16:   q = 16'd72;
            5'd17:   q = 16'd48;
            5'd18:   q = 16'd32;
            default: q = 16'd0;
        endcase
        return WORD_W'(q) >> shift;
    endfunction

endpackage

// ----- design/cpuavg_serial_unit.sv -----
// Shared bit-serial arithmetic unit: 32-bit wrapping multiply (shift and add)
// and 32-by-14-bit restoring divide, one bit per cycle. Uses cpuavg_pkg.
module cpuavg_serial_unit
    import cpuavg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    alu_op_t           op_reg, op_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [RATE_W-1:0] rem_reg, rem_next;

    logic [RATE_W:0]   rem_shift;
    logic [RATE_W:0]   divisor;
    logic              fits;

    assign rem_shift = {rem_reg, a_reg[WORD_W-1]};
    assign divisor   = {1'b0, b_reg[RATE_W-1:0]};
    assign fits      = rem_shift >= divisor;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            case (op_reg)
                OP_MUL:
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[WORD_W-2:0], 1'b0};
                    b_next = {1'b0, b_reg[WORD_W-1:1]};
                end
                OP_DIV:
                begin
                    rem_next = fits ? RATE_W'(rem_shift - divisor) : rem_shift[RATE_W-1:0];
                    a_next   = {a_reg[WORD_W-2:0], fits};
                end
                default:
                begin
                    a_next = a_reg;
                end
            endcase
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == OP_MUL) ? acc_reg : a_reg;

endmodule

// ----- design/cpu_usage_decaying_average.sv -----
// Top level of the decaying CPU-usage average with its sequencer and APB port.
// Depends on cpuavg_pkg, cpuavg_serial_unit and cpu_usage_decaying_average_assert.svh.
//
//  Channel   Signals                          Carries
//  s_*       tvalid tready tdata tuser        command and uptime in ticks
//  m_*       tvalid tready tdata              average, current ticks, percent
//  apb       psel penable pwrite paddr ...    ticks_per_second at address 0
//
// Every multiply and divide runs through one bit-serial unit.
// A first tick is taken in the idle state; a tick with no whole second elapsed passes
// through the check and finish states only; a query then adds one divide and three
// multiplies. A long gap adds up to ten operations for a tick or a query.
// Input is taken only while the sequencer is idle; a finished result waits in the
// output register while the next transaction is accepted. No clearing pass after reset.
module cpu_usage_decaying_average
    import cpuavg_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] now_ticks
    input  logic [CMD_W-1:0]     s_tuser,   // [1:0] cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] average, [52:32] current_ticks,
                                            // [73:53] estimate_percent, [79:74] zero
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [WORD_W-1:0]    pwdata,
    output logic [WORD_W-1:0]    prdata,
    output logic                 pready
);

    localparam int unsigned       TABLE_SHIFT = TABLE_Q - FRACTION_BITS;
    localparam logic [WORD_W-1:0] FSCALE      = WORD_W'(1) << FRACTION_BITS;
    localparam logic [WORD_W-1:0] C0          = low_coef(3'd0, TABLE_SHIFT);
    localparam logic [WORD_W-1:0] C0_COMP     = FSCALE - C0;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic                 query_reg, query_next;
    logic                 pend_reg, pend_next;
    logic [RATE_W-1:0]    tps_reg, tps_next;
    logic [WORD_W-1:0]    base_reg, base_next;
    logic [WORD_W-1:0]    run_reg, run_next;
    logic [WORD_W-1:0]    last_reg, last_next;
    logic [WORD_W-1:0]    avg_reg, avg_next;
    logic [WORD_W-1:0]    w_base_reg, w_base_next;
    logic [WORD_W-1:0]    w_run_reg, w_run_next;
    logic [WORD_W-1:0]    w_last_reg, w_last_next;
    logic [WORD_W-1:0]    w_avg_reg, w_avg_next;
    logic [WORD_W-1:0]    d_reg, d_next;
    logic [WORD_W-1:0]    q_reg, q_next;
    logic [WORD_W-1:0]    secs_reg, secs_next;
    logic [EST_W-1:0]     est_reg, est_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;

    logic                 accept;
    cmd_t                 cmd;
    logic [RATE_W-1:0]    hz;
    logic [WORD_W-1:0]    hz_w;
    logic                 behind;
    logic [WORD_W-1:0]    prod_sh;
    logic [WORD_W-1:0]    run_sh;
    logic                 secs_big;
    logic                 secs_mid;
    logic                 out_free;
    logic                 cfg_write;

    cpuavg_serial_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cmd       = cmd_t'(s_tuser);
    assign hz        = (tps_reg == '0) ? RATE_W'(1) : tps_reg;
    assign hz_w      = WORD_W'(hz);
    assign behind    = !d_reg[WORD_W-1] && (d_reg >= hz_w);
    assign prod_sh   = alu_rsp.result >> FRACTION_BITS;
    assign run_sh    = w_run_reg >> FRACTION_BITS;
    assign secs_big  = secs_reg > DECAY_LIMIT;
    assign secs_mid  = secs_reg > LOW_LIMIT;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == 1'b0);

    assign pready   = 1'b1;
    assign prdata   = (paddr[PADDR_W-1] == 1'b0) ? WORD_W'(tps_reg) : '0;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (base_reg != '0 || cmd == CMD_QUERY) &&
                    (cmd == CMD_TICK || cmd == CMD_QUERY))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!behind)
                begin
                    state_next = ST_FINISH;
                end
                else if (phase_reg == PH_REST)
                begin
                    state_next = ST_SECS_DIV;
                end
                else
                begin
                    state_next = ST_M_DIV;
                end
            end
            ST_M_DIV:
            begin
                if (alu_rsp.done)
                begin
                    state_next = ST_M_MUL1;
                end
            end
            ST_M_MUL1:
            begin
                if (alu_rsp.done)
                begin
                    state_next = ST_M_MUL2;
                end
            end
            ST_M_MUL2:
            begin
                if (alu_rsp.done)
                begin
                    state_next = ST_MERGED;
                end
            end
            ST_MERGED:
            begin
                state_next = (phase_reg == PH_FINAL) ? ST_EST_MUL : ST_CHECK;
            end
            ST_SECS_DIV:
            begin
                if (alu_rsp.done)
                begin
                    state_next = ST_BASE_MUL;
                end
            end
            ST_BASE_MUL:
            begin
                if (alu_rsp.done)
                begin
                    if (secs_big)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (secs_mid)
                    begin
                        state_next = ST_HIGH_MUL;
                    end
                    else if (secs_reg[2:0] != 3'd0)
                    begin
                        state_next = ST_LOW_MUL;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_HIGH_MUL:
            begin
                if (alu_rsp.done)
                begin
                    state_next = (secs_reg[2:0] != 3'd0) ? ST_LOW_MUL : ST_FINISH;
                end
            end
            ST_LOW_MUL:
            begin
                if (alu_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = query_reg ? ST_M_DIV : ST_IDLE;
            end
            ST_EST_MUL:
            begin
                if (alu_rsp.done)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        query_next   = query_reg;
        tps_next     = tps_reg;
        base_next    = base_reg;
        run_next     = run_reg;
        last_next    = last_reg;
        avg_next     = avg_reg;
        w_base_next  = w_base_reg;
        w_run_next   = w_run_reg;
        w_last_next  = w_last_reg;
        w_avg_next   = w_avg_reg;
        d_next       = d_reg;
        q_next       = q_reg;
        secs_next    = secs_reg;
        est_next     = est_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        alu_req      = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};

        if (cfg_write)
        begin
            tps_next = pwdata[RATE_W-1:0];
        end
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    w_base_next = base_reg;
                    w_run_next  = run_reg;
                    w_last_next = last_reg;
                    w_avg_next  = avg_reg;
                    d_next      = s_tdata - base_reg;
                    phase_next  = PH_FIRST;
                    query_next  = (cmd == CMD_QUERY);
                    case (cmd)
                        CMD_TICK:
                        begin
                            if (base_reg == '0)
                            begin
                                base_next = s_tdata;
                                run_next  = run_reg + FSCALE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            base_next = '0;
                            run_next  = '0;
                            last_next = '0;
                            avg_next  = '0;
                        end
                        default:
                        begin
                            base_next = base_reg;
                        end
                    endcase
                end
            end
            ST_M_DIV:
            begin
                alu_req = '{start: !pend_reg, op: OP_DIV, a: w_last_reg, b: hz_w};
                if (alu_rsp.done)
                begin
                    q_next = alu_rsp.result;
                end
            end
            ST_M_MUL1:
            begin
                alu_req = '{start: !pend_reg, op: OP_MUL, a: w_avg_reg, b: C0};
                if (alu_rsp.done)
                begin
                    w_avg_next = prod_sh;
                end
            end
            ST_M_MUL2:
            begin
                alu_req = '{start: !pend_reg, op: OP_MUL, a: q_reg, b: C0_COMP};
                if (alu_rsp.done)
                begin
                    w_avg_next = w_avg_reg + prod_sh;
                end
            end
            ST_MERGED:
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        w_last_next = w_run_reg;
                        w_run_next  = '0;
                        w_base_next = w_base_reg + hz_w;
                        d_next      = d_reg - hz_w;
                        phase_next  = PH_SECOND;
                    end
                    PH_SECOND:
                    begin
                        w_last_next = '0;
                        w_base_next = w_base_reg + hz_w;
                        d_next      = d_reg - hz_w;
                        phase_next  = PH_REST;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            ST_SECS_DIV:
            begin
                alu_req = '{start: !pend_reg, op: OP_DIV, a: d_reg, b: hz_w};
                if (alu_rsp.done)
                begin
                    secs_next = alu_rsp.result;
                end
            end
            ST_BASE_MUL:
            begin
                alu_req = '{start: !pend_reg, op: OP_MUL, a: secs_reg, b: hz_w};
                if (alu_rsp.done)
                begin
                    w_base_next = w_base_reg + alu_rsp.result;
                    if (secs_big)
                    begin
                        w_avg_next = '0;
                    end
                end
            end
            ST_HIGH_MUL:
            begin
                alu_req = '{start: !pend_reg, op: OP_MUL, a: w_avg_reg,
                            b: high_coef(secs_reg[7:3] - 5'd1, TABLE_SHIFT)};
                if (alu_rsp.done)
                begin
                    w_avg_next = prod_sh;
                end
            end
            ST_LOW_MUL:
            begin
                alu_req = '{start: !pend_reg, op: OP_MUL, a: w_avg_reg,
                            b: low_coef(secs_reg[2:0] - 3'd1, TABLE_SHIFT)};
                if (alu_rsp.done)
                begin
                    w_avg_next = prod_sh;
                end
            end
            ST_FINISH:
            begin
                if (query_reg)
                begin
                    phase_next = PH_FINAL;
                end
                else
                begin
                    base_next = w_base_reg;
                    run_next  = w_run_reg + FSCALE;
                    last_next = w_last_reg;
                    avg_next  = w_avg_reg;
                end
            end
            ST_EST_MUL:
            begin
                alu_req = '{start: !pend_reg, op: OP_MUL, a: q_reg, b: PERCENT};
                if (alu_rsp.done)
                begin
                    est_next = prod_sh[EST_W-1:0];
                end
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_W{1'b0}}, est_reg, run_sh[CUR_W-1:0], w_avg_reg};
                end
            end
            default:
            begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    assign pend_next = alu_req.start ? 1'b1 : (alu_rsp.done ? 1'b0 : pend_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_FIRST;
            query_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            tps_reg     <= RATE_RESET;
            base_reg    <= '0;
            run_reg     <= '0;
            last_reg    <= '0;
            avg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            query_reg   <= query_next;
            pend_reg    <= pend_next;
            tps_reg     <= tps_next;
            base_reg    <= base_next;
            run_reg     <= run_next;
            last_reg    <= last_next;
            avg_reg     <= avg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_base_reg <= w_base_next;
        w_run_reg  <= w_run_next;
        w_last_reg <= w_last_next;
        w_avg_reg  <= w_avg_next;
        d_reg      <= d_next;
        q_reg      <= q_next;
        secs_reg   <= secs_next;
        est_reg    <= est_next;
        m_data_reg <= m_data_next;
    end

`include "cpu_usage_decaying_average_assert.svh"

    `CUDA_ASSERT_NOW(a_done_needs_request, clk, rst_n, alu_rsp.done, pend_reg,
        "unit finished with no request outstanding")
    `CUDA_ASSERT_NEXT(a_tick_starts_work, clk, rst_n,
        accept && cmd == CMD_TICK && base_reg != '0, state_reg == ST_CHECK,
        "tick on a running window did not start the roll")
    `CUDA_ASSERT_NEXT(a_clear_zeroes, clk, rst_n, accept && cmd == CMD_CLEAR,
        base_reg == '0 && run_reg == '0 && avg_reg == '0, "clear left state behind")
    `CUDA_ASSERT_NEXT(a_query_keeps_state, clk, rst_n, query_reg && state_reg != ST_IDLE,
        $stable(run_reg) && $stable(avg_reg) && $stable(base_reg),
        "query changed the stored state")
    `CUDA_ASSERT_NOW(a_high_range, clk, rst_n, state_reg == ST_HIGH_MUL,
        secs_reg > LOW_LIMIT && secs_reg <= DECAY_LIMIT,
        "long decay used outside its table range")

endmodule
